// ===== rtl/rmb_pkg.sv =====
// ----------------------------------------------------------------------------
// rmb_pkg
// Types and constants shared by the run-length monochrome blitter.
// ----------------------------------------------------------------------------
package rmb_pkg;

  localparam int DIM_W    = 9;   // window coordinate and size fields
  localparam int CUR_W    = 18;  // pixel cursor inside the window
  localparam int LEN_W    = 8;
  localparam int RADDR_W  = 15;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;
  localparam int Q_DEPTH  = 2;   // power of two

  typedef enum logic {
    OP_RUN  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    K_RUN,
    K_SKIP,
    K_READ
  } kind_e;

  typedef enum logic [2:0] {
    REG_DEST_X,
    REG_DEST_Y,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_OVERWRITE_MODE
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_POS,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic               operation;
    logic [LEN_W-1:0]   run_length;
    logic               last_run;
    logic [RADDR_W-1:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [LEN_W-1:0] pixels_written;
    logic             image_done;
    logic             overflow;
  } out_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [LEN_W-1:0]   run_length;
    logic               last_run;
    logic [RADDR_W-1:0] read_address;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] dest_x;
    logic [DIM_W-1:0] dest_y;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             overwrite_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dest_x:         9'd0,
    dest_y:         9'd0,
    image_width:    9'd480,
    image_height:   9'd320,
    overwrite_mode: 1'b1
  };

endpackage

// ===== rtl/rmb_front.sv =====
// ----------------------------------------------------------------------------
// rmb_front
// Input queue: accepts items, classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module rmb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rmb_pkg::in_item_t item_i,
  input  logic             hold_i,
  output logic             full_o,
  input  logic             take_i,
  output logic             cmd_valid_o,
  output rmb_pkg::cmd_t    cmd_o
);
  import rmb_pkg::*;

  localparam int PtrW = $clog2(Q_DEPTH);
  localparam int CntW = $clog2(Q_DEPTH + 1);

  cmd_t            slot_q [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  cmd_t            new_cmd;
  logic            do_push, do_pop;

  always_comb begin
    new_cmd.run_length   = item_i.run_length;
    new_cmd.last_run     = item_i.last_run;
    new_cmd.read_address = item_i.read_address;
    if (op_e'(item_i.operation) == OP_READ) begin
      new_cmd.kind = K_READ;
    end else if (item_i.run_length == '0) begin
      new_cmd.kind = K_SKIP;
    end else begin
      new_cmd.kind = K_RUN;
    end
  end

  assign full_o      = hold_i || (cnt_q == CntW'(Q_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = take_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// ===== rtl/rmb_div.sv =====
// ----------------------------------------------------------------------------
// rmb_div
// Restoring divider, one quotient bit per cycle: cursor by window width.
// ----------------------------------------------------------------------------
module rmb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rmb_pkg::CUR_W-1:0] dividend_i,
  input  logic [rmb_pkg::DIM_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [rmb_pkg::CUR_W-1:0] quot_o,
  output logic [rmb_pkg::DIM_W-1:0] rem_o
);
  import rmb_pkg::*;

  localparam int CntW = $clog2(CUR_W + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [CUR_W-1:0] dq_q;
  logic [DIM_W-1:0] r_q, d_q;
  logic [DIM_W:0]   r_sh, r_nx;
  logic             ge;

  always_comb begin
    r_sh = {r_q, dq_q[CUR_W-1]};
    ge   = (r_sh >= {1'b0, d_q});
    r_nx = ge ? (r_sh - {1'b0, d_q}) : r_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(CUR_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q <= dividend_i;
      r_q  <= '0;
      d_q  <= divisor_i;
    end else if (busy_q) begin
      dq_q <= {dq_q[CUR_W-2:0], ge};
      r_q  <= r_nx[DIM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = r_q;

endmodule

// ===== rtl/rmb_back.sv =====
// ----------------------------------------------------------------------------
// rmb_back
// Blit engine: screen memory, clearing pass, run walker with byte-wide
// read-modify-write and screen byte reads.
// ----------------------------------------------------------------------------
module rmb_back #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmb_pkg::cfg_t      cfg_i,
  input  logic               cfg_wr_i,
  input  logic               cmd_valid_i,
  input  rmb_pkg::cmd_t      cmd_i,
  output logic               cmd_take_o,
  output logic               clearing_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output rmb_pkg::out_item_t res_o
);
  import rmb_pkg::*;

  localparam int ScreenPixels = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ScreenBytes  = (ScreenPixels + 7) / 8;
  localparam int MemAw        = $clog2(ScreenBytes);
  localparam int RowW         = $clog2(1024 * SCREEN_WIDTH + 1024);
  localparam int ScrW         = $clog2(ScreenPixels) + 1;
  localparam int PosW         = (RowW > ScrW) ? RowW : ScrW;

  back_state_e      state_q, state_d;
  logic [CUR_W-1:0] cursor_q, cursor_d, window_q;
  logic [DIM_W-1:0] w_q, w_d;
  logic [PosW-1:0]  rowbase_q, rowbase_d;
  logic             pol_q, pol_d, resync_q, resync_d;
  logic [LEN_W-1:0] rem_q, rem_d, written_q, written_d;
  logic             last_q, last_d, ovf_q, ovf_d;
  logic             is_read_q, is_read_d, rd_ok_q, rd_ok_d;
  logic [MemAw-1:0] clr_q, clr_d;

  logic             s2_valid_q, s2_valid_d, s2_fwd_q, s2_fwd_d;
  logic             s2_set_q, s2_set_d;
  logic [MemAw-1:0] s2_addr_q, s2_addr_d;
  logic [7:0]       s2_mask_q, s2_mask_d;
  logic [7:0]       s2_old, s2_new, last_wdata_q;

  logic [7:0]       mem [ScreenBytes];
  logic [7:0]       rd_data_q;
  logic             rd_en, mem_we;
  logic [MemAw-1:0] rd_addr, mem_waddr, byte_addr;
  logic [7:0]       mem_wdata;

  logic             div_start, div_done;
  logic [CUR_W-1:0] div_quot;
  logic [DIM_W-1:0] div_rem;

  logic [PosW-1:0]  pos, scr_left;
  logic [2:0]       off;
  logic [3:0]       n;
  logic [DIM_W-1:0] rowleft;
  logic             at_end, in_scr, row_end;
  logic [15:0]      mask16;
  logic [7:0]       mask;

  rmb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cursor_q),
    .divisor_i  (cfg_i.image_width),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // group of pixels that share one screen byte
  always_comb begin
    pos       = rowbase_q + PosW'(w_q);
    off       = pos[2:0];
    byte_addr = MemAw'(pos >> 3);
    rowleft   = cfg_i.image_width - w_q;
    at_end    = (cursor_q >= window_q);
    in_scr    = (pos < PosW'(ScreenPixels));
    scr_left  = PosW'(ScreenPixels) - pos;
    n         = 4'd8 - {1'b0, off};
    if (9'(rem_q) < 9'(n)) begin
      n = rem_q[3:0];
    end
    if (rowleft < 9'(n)) begin
      n = rowleft[3:0];
    end
    if (in_scr && (scr_left < PosW'(n))) begin
      n = scr_left[3:0];
    end
    row_end = (9'(n) == rowleft);
    mask16  = ((16'd1 << n) - 16'd1) << off;
    mask    = mask16[7:0];
  end

  always_comb begin
    s2_old = s2_fwd_q ? last_wdata_q : rd_data_q;
    if (cfg_i.overwrite_mode) begin
      s2_new = (s2_old & ~s2_mask_q) | (s2_set_q ? s2_mask_q : 8'd0);
    end else begin
      s2_new = s2_old | (s2_set_q ? s2_mask_q : 8'd0);
    end
  end

  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    w_d        = w_q;
    rowbase_d  = rowbase_q;
    pol_d      = pol_q;
    resync_d   = resync_q || cfg_wr_i;
    rem_d      = rem_q;
    last_d     = last_q;
    written_d  = written_q;
    ovf_d      = ovf_q;
    is_read_d  = is_read_q;
    rd_ok_d    = rd_ok_q;
    clr_d      = clr_q;
    s2_valid_d = 1'b0;
    s2_fwd_d   = 1'b0;
    s2_addr_d  = s2_addr_q;
    s2_mask_d  = s2_mask_q;
    s2_set_d   = s2_set_q;
    cmd_take_o = 1'b0;
    res_push_o = 1'b0;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = byte_addr;

    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == MemAw'(ScreenBytes - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + MemAw'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          last_d     = cmd_i.last_run;
          rem_d      = cmd_i.run_length;
          written_d  = '0;
          ovf_d      = 1'b0;
          is_read_d  = 1'b0;
          unique case (cmd_i.kind)
            K_READ: begin
              is_read_d = 1'b1;
              rd_en     = 1'b1;
              rd_addr   = MemAw'(cmd_i.read_address);
              rd_ok_d   = (32'(cmd_i.read_address) < ScreenBytes);
              state_d   = ST_OUT;
            end
            K_RUN: begin
              if (at_end) begin
                ovf_d   = 1'b1;
                state_d = ST_OUT;
              end else if (resync_q) begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end else begin
                state_d = ST_RUN;
              end
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        rowbase_d = PosW'((PosW'(cfg_i.dest_y) + PosW'(div_quot[DIM_W-1:0]))
                          * PosW'(SCREEN_WIDTH)) + PosW'(cfg_i.dest_x);
        w_d       = div_rem;
        resync_d  = cfg_wr_i;
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        if (at_end) begin
          ovf_d   = 1'b1;
          state_d = ST_DRAIN;
        end else begin
          if (in_scr) begin
            written_d  = written_q + LEN_W'(n);
            rd_en      = 1'b1;
            s2_valid_d = 1'b1;
            s2_addr_d  = byte_addr;
            s2_mask_d  = mask;
            s2_set_d   = pol_q;
            s2_fwd_d   = s2_valid_q && (s2_addr_q == byte_addr);
          end else begin
            ovf_d = 1'b1;
          end
          cursor_d = cursor_q + CUR_W'(n);
          if (row_end) begin
            w_d       = '0;
            rowbase_d = rowbase_q + PosW'(SCREEN_WIDTH);
          end else begin
            w_d = w_q + DIM_W'(n);
          end
          rem_d = rem_q - LEN_W'(n);
          if (rem_q == LEN_W'(n)) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!s2_valid_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
          if (!is_read_q) begin
            pol_d = ~pol_q;
            if (last_q) begin
              cursor_d = '0;
              w_d      = '0;
              pol_d    = 1'b0;
              resync_d = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.read_data      = (is_read_q && rd_ok_q) ? rd_data_q : 8'd0;
    res_o.pixels_written = is_read_q ? '0 : written_q;
    res_o.image_done     = !is_read_q && last_q;
    res_o.overflow       = !is_read_q && ovf_q;
  end

  assign clearing_o = (state_q == ST_CLEAR);
  assign mem_we     = clearing_o || s2_valid_q;
  assign mem_waddr  = clearing_o ? clr_q : s2_addr_q;
  assign mem_wdata  = clearing_o ? 8'd0 : s2_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cursor_q   <= '0;
      w_q        <= '0;
      pol_q      <= 1'b0;
      resync_q   <= 1'b1;
      clr_q      <= '0;
      s2_valid_q <= 1'b0;
      is_read_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cursor_q   <= cursor_d;
      w_q        <= w_d;
      pol_q      <= pol_d;
      resync_q   <= resync_d;
      clr_q      <= clr_d;
      s2_valid_q <= s2_valid_d;
      is_read_q  <= is_read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q  <= CUR_W'(cfg_i.image_width * cfg_i.image_height);
    rowbase_q <= rowbase_d;
    rem_q     <= rem_d;
    last_q    <= last_d;
    written_q <= written_d;
    ovf_q     <= ovf_d;
    rd_ok_q   <= rd_ok_d;
    s2_fwd_q  <= s2_fwd_d;
    s2_addr_q <= s2_addr_d;
    s2_mask_q <= s2_mask_d;
    s2_set_q  <= s2_set_d;
    if (s2_valid_q) begin
      last_wdata_q <= s2_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rmb_resq.sv =====
// ----------------------------------------------------------------------------
// rmb_resq
// Result queue between the blit engine and the result port.
// ----------------------------------------------------------------------------
module rmb_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rmb_pkg::out_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output rmb_pkg::out_item_t item_o
);
  import rmb_pkg::*;

  localparam int PtrW = $clog2(Q_DEPTH);
  localparam int CntW = $clog2(Q_DEPTH + 1);

  out_item_t       slot_q [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/rle_monochrome_blit_core.sv =====
// ----------------------------------------------------------------------------
// rle_monochrome_blit_core
// Run-length decoder that blits 1-bit images into a packed screen bitmap.
//
//   channel   direction  handshake            payload
//   input     in         push / full          in_item_i  (in_item_t)
//   result    out        pop / empty          out_item_o (out_item_t)
//   config    in/out     psel/penable/pready  paddr, pwdata, prdata
//
// A run touches about len/8 screen byte groups plus one per row crossed,
// doing one screen byte read-modify-write per cycle while it walks them; the
// first run of an image or after a register write first waits for the
// bit-serial cursor divider. After reset, full stays high while the screen
// memory is cleared one byte per cycle.
// Input and result queues hold two transfers each, so either side may stall.
// ----------------------------------------------------------------------------
module rle_monochrome_blit_core #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  rmb_pkg::in_item_t          in_item_i,
  output logic                       full,
  output logic                       empty,
  input  logic                       pop,
  output rmb_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rmb_pkg::APB_AW-1:0] paddr,
  input  logic [rmb_pkg::APB_DW-1:0] pwdata,
  output logic [rmb_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import rmb_pkg::*;

  cfg_t      cfg_q;
  logic      cfg_wr;
  reg_e      reg_idx;
  logic      cmd_valid, cmd_take, clearing;
  cmd_t      cmd;
  logic      res_full, res_push;
  out_item_t res;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEST_X:         cfg_q.dest_x         <= pwdata[DIM_W-1:0];
        REG_DEST_Y:         cfg_q.dest_y         <= pwdata[DIM_W-1:0];
        REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_q.image_height   <= pwdata[DIM_W-1:0];
        REG_OVERWRITE_MODE: cfg_q.overwrite_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEST_X:         prdata = APB_DW'(cfg_q.dest_x);
      REG_DEST_Y:         prdata = APB_DW'(cfg_q.dest_y);
      REG_IMAGE_WIDTH:    prdata = APB_DW'(cfg_q.image_width);
      REG_IMAGE_HEIGHT:   prdata = APB_DW'(cfg_q.image_height);
      REG_OVERWRITE_MODE: prdata = APB_DW'(cfg_q.overwrite_mode);
      default:            prdata = '0;
    endcase
  end

  rmb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .hold_i      (clearing),
    .full_o      (full),
    .take_i      (cmd_take),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  rmb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_wr_i    (cfg_wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .clearing_o  (clearing),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  rmb_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (out_item_o)
  );

endmodule
